// ----- src/rvx_pkg.sv -----
`default_nettype none
package rvx_pkg;

    localparam int NUM_REGS_DEF    = 16;
    localparam int STACK_DEPTH_DEF = 16;
    localparam int WORD_BYTES      = 8;
    localparam int LEN_IMM         = 1 + WORD_BYTES;
    localparam int LEN_REG         = 2;

    localparam logic [4:0] M_MOV  = 5'd0;
    localparam logic [4:0] M_ADD  = 5'd1;
    localparam logic [4:0] M_SUB  = 5'd2;
    localparam logic [4:0] M_MUL  = 5'd3;
    localparam logic [4:0] M_DIV  = 5'd4;
    localparam logic [4:0] M_OR   = 5'd5;
    localparam logic [4:0] M_NOR  = 5'd6;
    localparam logic [4:0] M_AND  = 5'd7;
    localparam logic [4:0] M_NAND = 5'd8;
    localparam logic [4:0] M_XOR  = 5'd9;
    localparam logic [4:0] M_XNOR = 5'd10;
    localparam logic [4:0] M_NOT  = 5'd11;
    localparam logic [4:0] M_CMP  = 5'd12;
    localparam logic [4:0] M_STR  = 5'd13;
    localparam logic [4:0] M_LD   = 5'd14;
    localparam logic [4:0] M_LDR  = 5'd15;
    localparam logic [4:0] M_JMP  = 5'd16;
    localparam logic [4:0] M_JG   = 5'd17;
    localparam logic [4:0] M_JGE  = 5'd18;
    localparam logic [4:0] M_JL   = 5'd19;
    localparam logic [4:0] M_JLE  = 5'd20;
    localparam logic [4:0] M_JE   = 5'd21;
    localparam logic [4:0] M_JNE  = 5'd22;
    localparam logic [4:0] M_OUT  = 5'd23;
    localparam logic [4:0] M_PUSH = 5'd24;
    localparam logic [4:0] M_POP  = 5'd25;

    localparam logic [1:0] ACT_NONE  = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_WRITE = 2'd2;
    localparam logic [1:0] ACT_OUT   = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_DIVZ  = 2'd3;

    typedef struct packed {
        logic [4:0]  mode;
        logic        use_imm;
        logic [3:0]  reg_a;
        logic [3:0]  reg_b;
        logic [63:0] operand_word;
    } in_t;

    typedef struct packed {
        logic [63:0] next_pc;
        logic [4:0]  flag_out;
        logic [1:0]  action;
        logic [63:0] mem_address;
        logic [63:0] data_word;
        logic [1:0]  status;
    } out_t;

endpackage
`default_nettype wire

// ----- src/rvx_ram.sv -----
`default_nettype none
module rvx_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ----- src/rvx_muldiv.sv -----
`default_nettype none
module rvx_muldiv (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic        is_div,
    input  wire logic [63:0] opa,
    input  wire logic [63:0] opb,
    output logic             done,
    output logic      [63:0] result
);

    logic [63:0] acc_reg, x_reg, y_reg;
    logic [5:0]  cnt_reg;
    logic        run_reg, div_reg, done_reg;
    logic [64:0] trial;
    logic        ge;

    assign trial  = {acc_reg, y_reg[63]};
    assign ge     = trial >= {1'b0, x_reg};
    assign done   = done_reg;
    assign result = div_reg ? y_reg : acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                div_reg <= is_div;
                cnt_reg <= '0;
                acc_reg <= '0;
                x_reg   <= is_div ? opb : opa;
                y_reg   <= is_div ? opa : opb;
            end
            else if (run_reg)
            begin
                if (div_reg)
                begin
                    acc_reg <= ge ? 64'(trial - {1'b0, x_reg}) : trial[63:0];
                    y_reg   <= {y_reg[62:0], ge};
                end
                else
                begin
                    acc_reg <= y_reg[0] ? acc_reg + x_reg : acc_reg;
                    x_reg   <= {x_reg[62:0], 1'b0};
                    y_reg   <= {1'b0, y_reg[63:1]};
                end
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule
`default_nettype wire

// ----- src/register_vm_execute_unit.sv -----
`default_nettype none
// channel | direction | beat
// in      | in        | in_data  (in_t), in_valid / in_stall
// out     | out       | out_data (out_t), out_valid / out_stall
// cfg     | in        | cfg_data, cfg_we (start_address)
// Simple instructions pass through accept, register read, execute and commit.
// mul and div also wait on the shift-add / restoring unit before commit.
// A result beat waits in the output register; the next beat may be accepted
// meanwhile, but commit waits while out_stall holds a full output register.
// Reset clears registers (valid bits), flags, pc and stack count at once.
module register_vm_execute_unit
    import rvx_pkg::*;
#(
    parameter int NUM_REGS    = NUM_REGS_DEF,
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire in_t         in_data,
    output logic             out_valid,
    input  wire logic        out_stall,
    output out_t             out_data,
    input  wire logic        cfg_we,
    input  wire logic [63:0] cfg_data
);

    localparam int RIW = $clog2(NUM_REGS);
    localparam int SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int SCW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [2:0] {S_IDLE, S_READ, S_EXEC, S_MD, S_DONE} state_t;

    function automatic logic [RIW-1:0] ridx(input logic [3:0] r);
        int v;
        v = int'(r);
        for (int i = 0; i < 8; i++)
        begin
            if (v >= NUM_REGS)
            begin
                v = v - NUM_REGS;
            end
        end
        return RIW'(v);
    endfunction

    state_t               state_reg;
    in_t                  item_reg;
    logic [NUM_REGS-1:0]  rfv_reg;
    logic [4:0]           flags_reg;
    logic [63:0]          pc_reg;
    logic [SCW-1:0]       sp_reg;
    out_t                 out_reg, pend_reg;
    logic                 out_valid_reg;
    logic [63:0]          res_reg, start_address_reg;
    logic                 wen_reg, push_reg, pop_reg;

    logic [RIW-1:0] ra, rb;
    logic [63:0]    rda, rdb, srd, a, b, r;
    logic [63:0]    len;
    logic           wen, push, pop, md, take;
    out_t           ex;
    logic [4:0]     cmpf;
    logic           commit;
    logic           md_done;
    logic [63:0]    md_result;
    logic [SCW-1:0] sp_dec;

    assign ra     = ridx(item_reg.reg_a);
    assign rb     = ridx(item_reg.reg_b);
    assign sp_dec = sp_reg - SCW'(1);
    assign commit = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);

    rvx_ram #(.WIDTH(64), .DEPTH(NUM_REGS)) u_rf_a (
        .clk(clk), .we(commit && wen_reg), .waddr(ra), .wdata(res_reg),
        .raddr(ra), .rdata(rda)
    );

    rvx_ram #(.WIDTH(64), .DEPTH(NUM_REGS)) u_rf_b (
        .clk(clk), .we(commit && wen_reg), .waddr(ra), .wdata(res_reg),
        .raddr(rb), .rdata(rdb)
    );

    rvx_ram #(.WIDTH(64), .DEPTH(STACK_DEPTH)) u_stack (
        .clk(clk), .we(commit && push_reg), .waddr(sp_reg[SAW-1:0]), .wdata(res_reg),
        .raddr(sp_dec[SAW-1:0]), .rdata(srd)
    );

    rvx_muldiv u_md (
        .clk(clk), .rst_n(rst_n), .start((state_reg == S_EXEC) && md),
        .is_div(item_reg.mode == M_DIV), .opa(a), .opb(b),
        .done(md_done), .result(md_result)
    );

    always_comb
    begin
        a    = rfv_reg[ra] ? rda : 64'd0;
        b    = item_reg.use_imm ? item_reg.operand_word : (rfv_reg[rb] ? rdb : 64'd0);
        len  = item_reg.use_imm ? 64'(LEN_IMM) : 64'(LEN_REG);
        cmpf = {a == b, a <= b, a < b, a >= b, a > b};
        r    = 64'd0;
        wen  = 1'b0;
        push = 1'b0;
        pop  = 1'b0;
        md   = 1'b0;
        take = 1'b0;
        ex.next_pc     = pc_reg;
        ex.flag_out    = flags_reg;
        ex.action      = ACT_NONE;
        ex.mem_address = 64'd0;
        ex.data_word   = 64'd0;
        ex.status      = ST_OK;
        case (item_reg.mode)
            M_MOV, M_ADD, M_SUB, M_OR, M_NOR, M_AND, M_NAND, M_XOR, M_XNOR:
            begin
                case (item_reg.mode)
                    M_MOV:   r = b;
                    M_ADD:   r = a + b;
                    M_SUB:   r = a - b;
                    M_OR:    r = a | b;
                    M_NOR:   r = ~(a | b);
                    M_AND:   r = a & b;
                    M_NAND:  r = ~(a & b);
                    M_XOR:   r = a ^ b;
                    default: r = ~(a ^ b);
                endcase
                wen = 1'b1;
                ex.next_pc = pc_reg + len;
            end
            M_NOT:
            begin
                r   = ~a;
                wen = 1'b1;
                ex.next_pc = pc_reg + 64'd1;
            end
            M_MUL:
            begin
                md  = 1'b1;
                wen = 1'b1;
                ex.next_pc = pc_reg + len;
            end
            M_DIV:
            begin
                if (b == 64'd0)
                begin
                    ex.status = ST_DIVZ;
                end
                else
                begin
                    md  = 1'b1;
                    wen = 1'b1;
                    ex.next_pc = pc_reg + len;
                end
            end
            M_CMP:
            begin
                ex.flag_out = cmpf;
                ex.next_pc  = pc_reg + len;
            end
            M_STR:
            begin
                ex.action      = ACT_WRITE;
                ex.mem_address = b;
                ex.data_word   = a;
                ex.next_pc     = pc_reg + len;
            end
            M_LD:
            begin
                ex.action      = ACT_READ;
                ex.mem_address = b;
                ex.next_pc     = pc_reg + len;
            end
            M_LDR:
            begin
                r   = item_reg.operand_word;
                wen = 1'b1;
            end
            M_JMP:
            begin
                ex.next_pc = item_reg.operand_word;
            end
            M_JG, M_JGE, M_JL, M_JLE, M_JE, M_JNE:
            begin
                case (item_reg.mode)
                    M_JG:    take = flags_reg[0];
                    M_JGE:   take = flags_reg[1];
                    M_JL:    take = flags_reg[2];
                    M_JLE:   take = flags_reg[3];
                    M_JE:    take = flags_reg[4];
                    default: take = !flags_reg[4];
                endcase
                ex.next_pc = take ? item_reg.operand_word : pc_reg + 64'(WORD_BYTES);
            end
            M_OUT:
            begin
                ex.action    = ACT_OUT;
                ex.data_word = item_reg.use_imm ? item_reg.operand_word : a;
                ex.next_pc   = pc_reg + (item_reg.use_imm ? 64'(WORD_BYTES) : 64'd1);
            end
            M_PUSH:
            begin
                if (sp_reg == SCW'(STACK_DEPTH))
                begin
                    ex.status = ST_FULL;
                end
                else
                begin
                    push = 1'b1;
                    r    = item_reg.use_imm ? item_reg.operand_word : a;
                    ex.next_pc = pc_reg + (item_reg.use_imm ? 64'(WORD_BYTES) : 64'd1);
                end
            end
            M_POP:
            begin
                if (sp_reg == '0)
                begin
                    ex.status = ST_EMPTY;
                end
                else
                begin
                    pop = 1'b1;
                    wen = 1'b1;
                    r   = srd;
                    ex.next_pc = pc_reg + 64'd1;
                end
            end
            default:
            begin
                r = 64'd0;
            end
        endcase
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            rfv_reg           <= '0;
            flags_reg         <= '0;
            pc_reg            <= '0;
            sp_reg            <= '0;
            out_valid_reg     <= 1'b0;
            start_address_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                start_address_reg <= cfg_data;
            end
            if (out_valid_reg && !out_stall && !commit)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        item_reg  <= in_data;
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    state_reg <= S_EXEC;
                end
                S_EXEC:
                begin
                    pend_reg  <= ex;
                    res_reg   <= r;
                    wen_reg   <= wen;
                    push_reg  <= push;
                    pop_reg   <= pop;
                    state_reg <= md ? S_MD : S_DONE;
                end
                S_MD:
                begin
                    if (md_done)
                    begin
                        res_reg   <= md_result;
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (commit)
                    begin
                        out_reg       <= pend_reg;
                        out_valid_reg <= 1'b1;
                        pc_reg        <= pend_reg.next_pc;
                        flags_reg     <= pend_reg.flag_out;
                        if (wen_reg)
                        begin
                            rfv_reg[ra] <= 1'b1;
                        end
                        if (push_reg)
                        begin
                            sp_reg <= sp_reg + SCW'(1);
                        end
                        else if (pop_reg)
                        begin
                            sp_reg <= sp_dec;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire
